@@ src/echo_distance_average_bar_core_assert.svh @@
// Assertion macros for the echo distance averager.
// Used by the top level, which supplies clk and rst_n in scope.
`ifndef ECHO_DISTANCE_AVERAGE_BAR_CORE_ASSERT_SVH
`define ECHO_DISTANCE_AVERAGE_BAR_CORE_ASSERT_SVH

// Checks a property at every clock edge outside reset.
`define EDAB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checks that a trigger is followed by a condition in the next cycle.
`define EDAB_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

@@ src/edab_pkg.sv @@
// Package for the echo distance averager: sizes, constants, register indexes,
// sequencer states and the control bundle. No dependencies.
`default_nettype none

package edab_pkg;

    localparam int WINDOW_LEN = 5;
    localparam int BAR_WIDTH  = 62;

    localparam int ECHO_W    = 20;
    localparam int DIST_W    = 16;
    localparam int CFG_W     = 8;
    localparam int FILL_W    = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_THRESH = 1'b1;

    localparam int SCALE_K     = 113742;
    localparam int LIMIT_SHIFT = 24;
    localparam int DIST_SHIFT  = LIMIT_SHIFT - 8;

    localparam int SLOT_W      = $clog2(WINDOW_LEN);
    localparam int SUM_W       = DIST_W + $clog2(WINDOW_LEN);
    localparam int RECIP_SHIFT = SUM_W + $clog2(WINDOW_LEN);

    localparam int MUL_W  = 24;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [MUL_W-1:0] RECIP = MUL_W'(((64'd1 << RECIP_SHIFT)
        + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

    localparam int SPAN   = BAR_WIDTH - 2;
    localparam int QUO_W  = $clog2(SPAN + 1);
    localparam int DBIT_W = $clog2(QUO_W);
    localparam int REM_W  = CFG_W + QUO_W;
    localparam int CNT_W  = (SLOT_W > DBIT_W) ? SLOT_W : DBIT_W;

    localparam int FILL_MAX   = (1 << FILL_W) - 1;
    localparam int FILL_LIMIT = (SPAN < FILL_MAX) ? SPAN : FILL_MAX;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_CHECK,
        ST_SUM,
        ST_AVG_MUL,
        ST_AVG,
        ST_BAR_MUL,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        MS_SCALE,
        MS_AVG,
        MS_BAR
    } mul_sel_t;

    typedef struct packed {
        logic              load_in;
        mul_sel_t          mul_sel;
        logic              prod_ld;
        logic              ring_upd;
        logic              sum_clr;
        logic              sum_en;
        logic [SLOT_W-1:0] sum_idx;
        logic              avg_ld;
        logic              bar_ld;
        logic              div_en;
        logic [DBIT_W-1:0] div_bit;
        logic              out_ld;
    } ctl_t;

endpackage

`default_nettype wire

@@ src/edab_ctrl.sv @@
// Sequencer of the echo distance averager: state machine and step counter
// that drive the shared datapath. Depends on edab_pkg.
`default_nettype none

module edab_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          out_busy,
    output logic               in_stall,
    output edab_pkg::ctl_t     ctl
);

    import edab_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = ST_SUM;
                cnt_next   = '0;
            end
            ST_SUM:
            begin
                if (cnt_reg == CNT_W'(WINDOW_LEN - 1))
                begin
                    state_next = ST_AVG_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_AVG_MUL:
            begin
                state_next = ST_AVG;
            end
            ST_AVG:
            begin
                state_next = ST_BAR_MUL;
                cnt_next   = CNT_W'(QUO_W - 1);
            end
            ST_BAR_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (!out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl         = '0;
        ctl.mul_sel = MS_SCALE;
        ctl.sum_idx = cnt_reg[SLOT_W-1:0];
        ctl.div_bit = cnt_reg[DBIT_W-1:0];
        in_stall    = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                ctl.load_in = in_valid;
            end
            ST_SCALE:
            begin
                ctl.mul_sel = MS_SCALE;
                ctl.prod_ld = 1'b1;
            end
            ST_CHECK:
            begin
                ctl.ring_upd = 1'b1;
                ctl.sum_clr  = 1'b1;
            end
            ST_SUM:
            begin
                ctl.sum_en = 1'b1;
            end
            ST_AVG_MUL:
            begin
                ctl.mul_sel = MS_AVG;
                ctl.prod_ld = 1'b1;
            end
            ST_AVG:
            begin
                ctl.avg_ld = 1'b1;
            end
            ST_BAR_MUL:
            begin
                ctl.mul_sel = MS_BAR;
                ctl.bar_ld  = 1'b1;
            end
            ST_DIV:
            begin
                ctl.div_en = 1'b1;
            end
            ST_FINISH:
            begin
                ctl.out_ld = !out_busy;
            end
            default:
            begin
                ctl.load_in = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/edab_dp.sv @@
// Datapath of the echo distance averager: configuration registers, sample
// ring, shared multiplier, accumulator, divider step and output register.
// Depends on edab_pkg.
`default_nettype none

module edab_dp
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [edab_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [edab_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic [edab_pkg::ECHO_W-1:0]      echo_us,
    input  wire edab_pkg::ctl_t                   ctl,
    input  wire logic                             out_stall,
    output logic                                  out_valid,
    output logic                                  out_busy,
    output logic [edab_pkg::DIST_W-1:0]           avg_distance,
    output logic [edab_pkg::FILL_W-1:0]           bar_fill,
    output logic                                  sample_accepted
);

    import edab_pkg::*;

    logic [CFG_W-1:0]   max_reg;
    logic [CFG_W-1:0]   far_reg;
    logic [DIST_W-1:0]  ring_reg [WINDOW_LEN];
    logic [SLOT_W-1:0]  slot_reg;
    logic [SLOT_W-1:0]  slot_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    logic [ECHO_W-1:0]  echo_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               accepted_reg;
    logic [SUM_W-1:0]   acc_reg;
    logic [DIST_W-1:0]  avg_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [QUO_W-1:0]   q_reg;
    logic [DIST_W-1:0]  avg_out_reg;
    logic [FILL_W-1:0]  fill_out_reg;
    logic               acc_out_reg;

    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [CFG_W-1:0]   clamp_c;
    logic               take;
    logic [REM_W-1:0]   div_sh;
    logic               div_ge;
    logic [QUO_W-1:0]   span_diff;
    logic [FILL_W-1:0]  fill_val;

    assign clamp_c = (avg_reg[DIST_W-1 -: CFG_W] > far_reg) ? far_reg
                                                           : avg_reg[DIST_W-1 -: CFG_W];

    always_comb
    begin
        unique case (ctl.mul_sel)
            MS_SCALE:
            begin
                mul_a = MUL_W'(echo_reg);
                mul_b = MUL_W'(SCALE_K);
            end
            MS_AVG:
            begin
                mul_a = MUL_W'(acc_reg);
                mul_b = RECIP;
            end
            MS_BAR:
            begin
                mul_a = MUL_W'(clamp_c);
                mul_b = MUL_W'(SPAN);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign take = (prod_reg <= (PROD_W'(max_reg) << LIMIT_SHIFT));

    assign slot_next = (slot_reg == SLOT_W'(WINDOW_LEN - 1)) ? '0
                                                             : slot_reg + SLOT_W'(1);

    assign div_sh = REM_W'(far_reg) << ctl.div_bit;
    assign div_ge = (rem_reg >= div_sh);

    assign span_diff = QUO_W'(SPAN) - q_reg;

    always_comb
    begin
        if (far_reg == '0)
        begin
            fill_val = '0;
        end
        else if (8'(span_diff) > 8'(FILL_MAX))
        begin
            fill_val = FILL_W'(FILL_MAX);
        end
        else
        begin
            fill_val = FILL_W'(span_diff);
        end
    end

    always_comb
    begin
        if (ctl.out_ld)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg       <= CFG_W'(60);
            far_reg       <= CFG_W'(24);
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we && (cfg_index == REG_MAX_RANGE))
            begin
                max_reg <= cfg_data;
            end
            else if (cfg_we && (cfg_index == REG_FAR_THRESH))
            begin
                far_reg <= cfg_data;
            end
            if (ctl.ring_upd && take)
            begin
                ring_reg[slot_reg] <= prod_reg[DIST_SHIFT +: DIST_W];
                slot_reg           <= slot_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            echo_reg <= echo_us;
        end
        if (ctl.prod_ld)
        begin
            prod_reg <= mul_p;
        end
        if (ctl.ring_upd)
        begin
            accepted_reg <= take;
        end
        if (ctl.sum_clr)
        begin
            acc_reg <= '0;
        end
        else if (ctl.sum_en)
        begin
            acc_reg <= acc_reg + SUM_W'(ring_reg[ctl.sum_idx]);
        end
        if (ctl.avg_ld)
        begin
            avg_reg <= prod_reg[RECIP_SHIFT +: DIST_W];
        end
        if (ctl.bar_ld)
        begin
            rem_reg <= mul_p[REM_W-1:0];
            q_reg   <= '0;
        end
        else if (ctl.div_en && div_ge)
        begin
            rem_reg             <= rem_reg - div_sh;
            q_reg[ctl.div_bit]  <= 1'b1;
        end
        if (ctl.out_ld)
        begin
            avg_out_reg  <= avg_reg;
            fill_out_reg <= fill_val;
            acc_out_reg  <= accepted_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_busy        = out_valid_reg && out_stall;
    assign avg_distance    = avg_out_reg;
    assign bar_fill        = fill_out_reg;
    assign sample_accepted = acc_out_reg;

endmodule

`default_nettype wire

@@ src/echo_distance_average_bar_core.sv @@
// Top level of the echo distance averager with bar fill output.
// Instantiates edab_ctrl and edab_dp; depends on edab_pkg and the assertion header.
//
// Each input beat on in_valid/in_stall carries one echo width in microseconds.
// The block scales it to a distance in 1/256 inch, stores it in a five-entry
// ring when it lies within the maximum range register, and returns one output
// beat with the ring average, the bar fill width and a flag telling whether the
// reading was stored. One shared multiplier does the scaling, the reciprocal
// division by the window length and the bar product; the bar quotient comes
// from a restoring divider that resolves one bit per cycle.
// An item keeps in_stall high from acceptance until its result is loaded into
// the output register, so a new item is taken only once the last one is done.
// The ring sum is one entry per cycle and the divider one quotient bit per cycle.
// If the receiver stalls, the result waits in the output register; a further
// item may be accepted meanwhile and is held in its final step until the
// output register is free. Configuration writes on cfg_we take effect at the
// next edge and are meant for idle periods. Reset clears the ring to zero,
// restores the register defaults of 60 and 24 inches and drops any result.
`default_nettype none

module echo_distance_average_bar_core
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [edab_pkg::ECHO_W-1:0]      echo_us,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [edab_pkg::DIST_W-1:0]           avg_distance,
    output logic [edab_pkg::FILL_W-1:0]           bar_fill,
    output logic                                  sample_accepted,
    input  wire logic                             cfg_we,
    input  wire logic [edab_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [edab_pkg::CFG_W-1:0]       cfg_data
);

    import edab_pkg::*;

`include "echo_distance_average_bar_core_assert.svh"

    ctl_t   ctl;
    logic   out_busy;

    edab_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_busy (out_busy),
        .in_stall (in_stall),
        .ctl      (ctl)
    );

    edab_dp u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .echo_us         (echo_us),
        .ctl             (ctl),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .out_busy        (out_busy),
        .avg_distance    (avg_distance),
        .bar_fill        (bar_fill),
        .sample_accepted (sample_accepted)
    );

    `EDAB_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "no stall after beat")
    `EDAB_ASSERT(a_fill_range, out_valid |-> (8'(bar_fill) <= 8'(FILL_LIMIT)), "fill too wide")
    `EDAB_ASSERT(a_no_overwrite, ctl.out_ld |-> !(out_valid && out_stall), "held beat lost")

endmodule

`default_nettype wire

@@ dv/echo_distance_average_bar_core_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for echo_distance_average_bar_core: drives echo widths and
// register writes, predicts every output beat and compares it. Depends on edab_pkg.

module echo_distance_average_bar_core_test;

    import edab_pkg::*;

    localparam int unsigned ECHO_SCALE  = 113742;
    localparam int unsigned LATENCY     = 20;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned REPORT_MAX  = 10;

    typedef struct packed {
        logic [DIST_W-1:0] avg_distance;
        logic [FILL_W-1:0] bar_fill;
        logic              sample_accepted;
    } reading_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [ECHO_W-1:0]    echo_us;
    logic                 out_valid;
    logic                 out_stall;
    logic [DIST_W-1:0]    avg_distance;
    logic [FILL_W-1:0]    bar_fill;
    logic                 sample_accepted;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    logic [DIST_W-1:0]    distance_ring [WINDOW_LEN];
    int unsigned          ring_slot;
    logic [CFG_W-1:0]     max_range_reg;
    logic [CFG_W-1:0]     far_reg;
    reading_t             pending_readings [$];
    int unsigned          mismatches;
    int unsigned          cycle_count;
    int unsigned          burst_left;
    int unsigned          stall_mode;

    echo_distance_average_bar_core i_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .echo_us         (echo_us),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .avg_distance    (avg_distance),
        .bar_fill        (bar_fill),
        .sample_accepted (sample_accepted),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic reading_t predict_reading(input logic [ECHO_W-1:0] echo);
        logic [63:0] product;
        logic [63:0] range_limit;
        int unsigned total;
        int unsigned mean;
        int unsigned span;
        int unsigned clamped;
        int unsigned fill;
        reading_t    r;
        product = 64'(echo) * 64'(ECHO_SCALE);
        range_limit = 64'(max_range_reg) << 24;
        r.sample_accepted = (product <= range_limit);
        if (r.sample_accepted)
        begin
            distance_ring[ring_slot] = product[31:16];
            ring_slot = (ring_slot == WINDOW_LEN - 1) ? 0 : ring_slot + 1;
        end
        total = 0;
        for (int i = 0; i < WINDOW_LEN; i++)
            total += distance_ring[i];
        mean = total / WINDOW_LEN;
        span = BAR_WIDTH - 2;
        if (far_reg == 0)
            fill = 0;
        else
        begin
            clamped = mean >> 8;
            if (clamped > far_reg)
                clamped = far_reg;
            fill = span - (clamped * span) / far_reg;
            if (fill > 63)
                fill = 63;
        end
        r.avg_distance = mean[DIST_W-1:0];
        r.bar_fill = fill[FILL_W-1:0];
        return r;
    endfunction

    function automatic int unsigned accept_threshold();
        return int'((64'(max_range_reg) << 24) / 64'(ECHO_SCALE));
    endfunction

    function automatic logic [ECHO_W-1:0] pick_echo();
        int unsigned thr;
        int unsigned top;
        thr = accept_threshold();
        top = thr * 2 + 16;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return ECHO_W'($urandom_range(0, thr));
            6:       return ECHO_W'(thr + $urandom_range(0, 2) - ((thr > 0) ? 1 : 0));
            7:       return ECHO_W'($urandom_range(0, (1 << ECHO_W) - 1));
            8:       return ($urandom_range(0, 1) == 1) ? {ECHO_W{1'b1}} : '0;
            default: return ECHO_W'($urandom_range(thr, top));
        endcase
    endfunction

    task automatic send_echo(input logic [ECHO_W-1:0] echo);
        int unsigned gap;
        @(negedge clk);
        in_valid <= 1'b1;
        echo_us  <= echo;
        do
            @(posedge clk);
        while (in_stall);
        pending_readings.push_back(predict_reading(echo));
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(0, 7);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                echo_us  <= ECHO_W'($urandom);
                repeat (gap - 1)
                    @(negedge clk);
            end
        end
        else
            burst_left--;
    endtask

    task automatic wait_results_done();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_W-1:0] value);
        wait_results_done();
        repeat (LATENCY)
            @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (index == REG_MAX_RANGE)
            max_range_reg = value;
        else
            far_reg = value;
    endtask

    task automatic set_ranges(input logic [CFG_W-1:0] max_range, input logic [CFG_W-1:0] far);
        write_register(REG_MAX_RANGE, max_range);
        write_register(REG_FAR_THRESH, far);
    endtask

    task automatic send_boundary();
        int unsigned thr;
        thr = accept_threshold();
        send_echo(ECHO_W'(thr));
        send_echo(ECHO_W'(thr + 1));
    endtask

    task automatic test_early_averages();
        send_echo('0);
        send_echo(ECHO_W'(1));
        send_echo(ECHO_W'(1000));
        send_boundary();
        send_echo({ECHO_W{1'b1}});
        send_echo(ECHO_W'(20'h55555));
        send_echo(ECHO_W'(20'hAAAAA));
        send_echo(ECHO_W'(3000));
    endtask

    task automatic test_range_extremes();
        set_ranges(8'd255, 8'd255);
        send_boundary();
        send_echo(ECHO_W'(30000));
        set_ranges(8'd0, 8'd0);
        send_echo('0);
        send_echo(ECHO_W'(1));
        send_echo(ECHO_W'(100));
        set_ranges(8'd1, 8'd1);
        send_echo('0);
        send_boundary();
        send_echo(ECHO_W'(100));
        set_ranges(8'd255, 8'd1);
        send_echo(ECHO_W'(37000));
        send_echo(ECHO_W'(20));
    endtask

    task automatic run_random_phase(input logic [CFG_W-1:0] max_range,
                                    input logic [CFG_W-1:0] far, input int unsigned count);
        set_ranges(max_range, far);
        repeat (count)
            send_echo(pick_echo());
    endtask

    task automatic test_random_settings();
        run_random_phase(8'd60, 8'd24, 200);
        run_random_phase(8'd255, 8'd255, 150);
        run_random_phase(8'd255, 8'd1, 100);
        run_random_phase(8'd0, 8'd0, 60);
        run_random_phase(8'd1, 8'd255, 60);
        repeat (3)
            run_random_phase(CFG_W'($urandom_range(0, 255)), CFG_W'($urandom_range(0, 255)), 100);
    endtask

    task automatic test_drain_between_bursts();
        set_ranges(8'd120, 8'd40);
        repeat (20)
        begin
            repeat ($urandom_range(1, 5))
                send_echo(pick_echo());
            wait_results_done();
        end
    endtask

    always @(negedge clk)
    begin
        if (cycle_count % 128 == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 2) == 0);
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        reading_t got;
        reading_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("echo_distance_average_bar_core test failed");
            $finish;
        end
        else if (rst_n && out_valid && !out_stall)
        begin
            got.avg_distance = avg_distance;
            got.bar_fill = bar_fill;
            got.sample_accepted = sample_accepted;
            if (pending_readings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected beat: avg %0d fill %0d accepted %0d",
                             got.avg_distance, got.bar_fill, got.sample_accepted);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("mismatch: avg %0d/%0d fill %0d/%0d accepted %0d/%0d (exp/act)",
                                 want.avg_distance, got.avg_distance, want.bar_fill,
                                 got.bar_fill, want.sample_accepted, got.sample_accepted);
                end
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        echo_us     = '0;
        out_stall   = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_MAX_RANGE;
        cfg_data    = '0;
        mismatches  = 0;
        cycle_count = 0;
        burst_left  = 0;
        stall_mode  = 0;
        ring_slot   = 0;
        max_range_reg = 8'd60;
        far_reg       = 8'd24;
        for (int i = 0; i < WINDOW_LEN; i++)
            distance_ring[i] = '0;
        repeat (2)
            @(negedge clk);
        rst_n = 1'b1;

        test_early_averages();
        test_range_extremes();
        test_random_settings();
        test_drain_between_bursts();

        wait_results_done();
        repeat (LATENCY)
            @(posedge clk);
        if (mismatches == 0)
            $display("echo_distance_average_bar_core test passed");
        else
            $display("echo_distance_average_bar_core test failed");
        $finish;
    end

endmodule
